// File: hdl/eevr_pkg.sv
// Shared types and constants for the edge event varint ring recorder.
// Used by eevr_ctrl, eevr_dp and the top level; depends on nothing else.
package eevr_pkg;

   localparam int TIME_W      = 48;
   localparam int AGE_W       = TIME_W + 1;
   localparam int VAL_W       = 63;
   localparam int SUM_W       = 64;
   localparam int MAX_SIGNALS = 16;
   localparam int SIG_W       = 4;
   localparam int MAX_REC     = 9;
   localparam int CSR_W       = 14;

   localparam logic CSR_SIGNAL_COUNT = 1'b0;
   localparam logic CSR_RING_BYTES   = 1'b1;

   typedef enum logic [1:0] {
      MODE_EDGE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_START = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_FULL    = 3'd1,
      ST_IGNORED = 3'd2,
      ST_RECORD  = 3'd3,
      ST_NOTHING = 3'd4
   } status_type;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       ev_prep;
      logic       ev_size;
      logic       ev_fail;
      logic       wr_data;
      logic       wr_glitch;
      logic       ev_commit;
      logic       rd_init;
      logic       rd_issue;
      logic       rd_take;
      logic       rd_eval;
      logic       rd_commit;
      logic       set_res;
      status_type res_code;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     sig_enabled;
      logic     ring_empty;
      logic     ev_full;
      logic     wr_last;
      logic     glitch;
      logic     rd_more;
      logic     rd_ok;
   } stat_type;

endpackage

// File: hdl/eevr_dp.sv
// Datapath of the edge event recorder: ring memory, pointers, times, levels,
// varint packing and unpacking, and the result registers. Depends on eevr_pkg.
module eevr_dp #(
   parameter int RING_DEPTH = 8192
) (
   input  logic                                clock,
   input  logic                                reset,
   input  eevr_pkg::cmd_type                   cmd,
   output eevr_pkg::stat_type                  stat,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [eevr_pkg::CSR_W-1:0]          csr_data,
   input  logic [1:0]                          req_mode,
   input  logic [eevr_pkg::SIG_W-1:0]          req_signal_index,
   input  logic                                req_pin_level,
   input  logic [eevr_pkg::TIME_W-1:0]         req_now_time,
   input  logic [eevr_pkg::MAX_SIGNALS-1:0]    req_start_levels,
   output logic [2:0]                          rsp_status,
   output logic [eevr_pkg::SIG_W-1:0]          rsp_record_signal,
   output logic                                rsp_record_falling,
   output logic signed [eevr_pkg::AGE_W-1:0]   rsp_record_age,
   output logic                                rsp_overflow_seen
);

   localparam int PW = $clog2(RING_DEPTH);
   localparam int SW = PW + 1;
   localparam int DW = SW + 1;
   localparam int CW = (SW > eevr_pkg::CSR_W) ? SW : eevr_pkg::CSR_W;
   localparam int RESET_SIZE = (RING_DEPTH < 8192) ? RING_DEPTH : 8192;
   localparam int NS = eevr_pkg::MAX_SIGNALS;
   localparam int TW = eevr_pkg::TIME_W;

   logic [7:0] mem [RING_DEPTH];
   logic [7:0] rdata_ff;

   logic [4:0]                 count_raw_ff;
   logic [eevr_pkg::CSR_W-1:0] bytes_raw_ff;
   logic [SW-1:0]              ring_size_ff;
   logic [2:0]                 ib_ff;
   logic [PW-1:0]              wp_ff, rp_ff, work_ff;
   logic [TW-1:0]              lwt_ff, lrt_ff;
   logic [NS-1:0]              wlev_ff, rlev_ff, enabled_ff;
   logic                       ovf_ff;

   logic [1:0]                 mode_ff;
   logic [eevr_pkg::SIG_W-1:0] sig_ff;
   logic                       level_ff;
   logic [TW-1:0]              now_ff;
   logic [NS-1:0]              slev_ff;

   logic [eevr_pkg::VAL_W-1:0] val_ff;
   logic                       glitch_ff;
   logic [3:0]                 n_ff;
   logic [DW-1:0]              dist_ff;
   logic [3:0]                 cnt_ff;
   logic [eevr_pkg::SIG_W-1:0] idx_ff;
   logic [eevr_pkg::SUM_W-1:0] sum_ff;

   logic [2:0]                 res_status_ff;
   logic [eevr_pkg::SIG_W-1:0] res_sig_ff;
   logic                       res_fall_ff;
   logic [eevr_pkg::AGE_W-1:0] res_age_ff;

   logic [4:0]                 cnt_clamp;
   logic [NS-1:0]              all_mask;
   logic [2:0]                 ib_in;
   logic [CW-1:0]              bytes_ext;
   logic [SW-1:0]              size_in;
   logic [SW-1:0]              work_inc;
   logic [PW-1:0]              work_next;
   logic [TW-1:0]              delta;
   logic [eevr_pkg::VAL_W-1:0] val_prep;
   logic [3:0]                 ndata;
   logic [DW-1:0]              dist_in;
   logic [7:0]                 wdata;
   logic                       mem_we;
   logic [eevr_pkg::VAL_W-1:0] val_acc;
   logic [eevr_pkg::SIG_W-1:0] idx_mask;
   logic [eevr_pkg::VAL_W-1:0] dec_delta;

   always_comb begin
      if (count_raw_ff == 5'd0) begin
         cnt_clamp = 5'd1;
      end else if (count_raw_ff > 5'(NS)) begin
         cnt_clamp = 5'(NS);
      end else begin
         cnt_clamp = count_raw_ff;
      end
      for (int i = 0; i < NS; i++) begin
         all_mask[i] = (5'(i) < cnt_clamp);
      end
      if (cnt_clamp <= 5'd1) begin
         ib_in = 3'd0;
      end else if (cnt_clamp <= 5'd2) begin
         ib_in = 3'd1;
      end else if (cnt_clamp <= 5'd4) begin
         ib_in = 3'd2;
      end else if (cnt_clamp <= 5'd8) begin
         ib_in = 3'd3;
      end else begin
         ib_in = 3'd4;
      end
      bytes_ext = CW'(bytes_raw_ff);
      if (bytes_ext < CW'(2)) begin
         size_in = SW'(2);
      end else if (bytes_ext > CW'(RING_DEPTH)) begin
         size_in = SW'(RING_DEPTH);
      end else begin
         size_in = SW'(bytes_ext);
      end
   end

   always_comb begin
      work_inc  = {1'b0, work_ff} + SW'(1);
      work_next = (work_inc == ring_size_ff) ? '0 : work_inc[PW-1:0];
      delta     = now_ff - lwt_ff;
      val_prep  = (eevr_pkg::VAL_W'(delta) << ib_ff)
                  | eevr_pkg::VAL_W'(sig_ff);
      ndata = 4'd1;
      for (int k = 1; k < eevr_pkg::MAX_REC; k++) begin
         if ((val_ff >> (7 * k)) != '0) begin
            ndata = 4'(k + 1);
         end
      end
      if (rp_ff > wp_ff) begin
         dist_in = DW'(rp_ff) - DW'(wp_ff);
      end else begin
         dist_in = DW'(rp_ff) + DW'(ring_size_ff) - DW'(wp_ff);
      end
      mem_we = cmd.wr_data | cmd.wr_glitch;
      if (cmd.wr_data) begin
         wdata = {|val_ff[eevr_pkg::VAL_W-1:7], val_ff[6:0]};
      end else begin
         wdata = {4'd0, sig_ff};
      end
      val_acc = val_ff;
      for (int k = 0; k < eevr_pkg::MAX_REC; k++) begin
         if (cnt_ff == 4'(k)) begin
            val_acc[7*k +: 7] = val_ff[7*k +: 7] | rdata_ff[6:0];
         end
      end
      idx_mask  = eevr_pkg::SIG_W'((5'd1 << ib_ff) - 5'd1);
      dec_delta = val_ff >> ib_ff;
   end

   always_comb begin
      stat.mode        = eevr_pkg::mode_type'(mode_ff);
      stat.sig_enabled = enabled_ff[sig_ff];
      stat.ring_empty  = (rp_ff == wp_ff);
      stat.ev_full     = (DW'(n_ff) >= dist_ff);
      stat.wr_last     = ~|val_ff[eevr_pkg::VAL_W-1:7];
      stat.glitch      = glitch_ff;
      stat.rd_more     = rdata_ff[7] & (cnt_ff < 4'(eevr_pkg::MAX_REC - 1));
      stat.rd_ok       = (sum_ff <= eevr_pkg::SUM_W'(now_ff));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[work_ff] <= wdata;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= mem[work_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_raw_ff <= 5'd1;
         bytes_raw_ff <= eevr_pkg::CSR_W'(8192);
         ring_size_ff <= SW'(RESET_SIZE);
         ib_ff        <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         lwt_ff       <= '0;
         lrt_ff       <= '0;
         wlev_ff      <= '0;
         rlev_ff      <= '0;
         enabled_ff   <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               eevr_pkg::CSR_SIGNAL_COUNT: count_raw_ff <= csr_data[4:0];
               eevr_pkg::CSR_RING_BYTES:   bytes_raw_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.start) begin
            ring_size_ff <= size_in;
            ib_ff        <= ib_in;
            wp_ff        <= '0;
            rp_ff        <= '0;
            ovf_ff       <= 1'b0;
            lwt_ff       <= now_ff;
            lrt_ff       <= now_ff;
            wlev_ff      <= slev_ff & all_mask;
            rlev_ff      <= slev_ff & all_mask;
            enabled_ff   <= all_mask;
         end
         if (cmd.ev_fail) begin
            ovf_ff              <= 1'b1;
            enabled_ff[sig_ff]  <= 1'b0;
         end
         if (cmd.ev_commit) begin
            wp_ff  <= work_ff;
            lwt_ff <= now_ff;
            if (!glitch_ff) begin
               wlev_ff[sig_ff] <= ~wlev_ff[sig_ff];
            end
         end
         if (cmd.rd_commit) begin
            rp_ff           <= work_ff;
            lrt_ff          <= sum_ff[TW-1:0];
            rlev_ff[idx_ff] <= ~rlev_ff[idx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         sig_ff   <= req_signal_index;
         level_ff <= req_pin_level;
         now_ff   <= req_now_time;
         slev_ff  <= req_start_levels;
      end
      if (cmd.ev_prep) begin
         val_ff    <= val_prep;
         glitch_ff <= (wlev_ff[sig_ff] == level_ff);
         work_ff   <= wp_ff;
      end
      if (cmd.ev_size) begin
         n_ff    <= ndata + 4'(glitch_ff);
         dist_ff <= dist_in;
      end
      if (cmd.wr_data) begin
         val_ff  <= val_ff >> 7;
         work_ff <= work_next;
      end
      if (cmd.wr_glitch) begin
         work_ff <= work_next;
      end
      if (cmd.rd_init) begin
         val_ff  <= '0;
         cnt_ff  <= '0;
         work_ff <= rp_ff;
      end
      if (cmd.rd_issue) begin
         work_ff <= work_next;
      end
      if (cmd.rd_take) begin
         val_ff <= val_acc;
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (cmd.rd_eval) begin
         idx_ff <= val_ff[eevr_pkg::SIG_W-1:0] & idx_mask;
         sum_ff <= eevr_pkg::SUM_W'(lrt_ff) + eevr_pkg::SUM_W'(dec_delta);
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_code;
         if (cmd.rd_commit) begin
            res_sig_ff  <= idx_ff;
            res_fall_ff <= rlev_ff[idx_ff];
            res_age_ff  <= eevr_pkg::AGE_W'(sum_ff[TW-1:0]) - eevr_pkg::AGE_W'(now_ff);
         end else begin
            res_sig_ff  <= '0;
            res_fall_ff <= 1'b0;
            res_age_ff  <= '0;
         end
      end
      if (cmd.out_load) begin
         rsp_status         <= res_status_ff;
         rsp_record_signal  <= res_sig_ff;
         rsp_record_falling <= res_fall_ff;
         rsp_record_age     <= res_age_ff;
         rsp_overflow_seen  <= ovf_ff;
      end
   end

`ifndef SYNTH
   a_wp_in_ring: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wp_ff} < ring_size_ff) else $error("write pointer beyond ring size");
   a_rp_in_ring: assert property (@(posedge clock) disable iff (reset)
      {1'b0, rp_ff} < ring_size_ff) else $error("read pointer beyond ring size");
   a_dec_len: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_take |-> cnt_ff < 4'(eevr_pkg::MAX_REC))
      else $error("record decode ran past nine bytes");
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(ovf_ff) |-> $past(cmd.start)) else $error("overflow flag cleared without start");
`endif

endmodule

// File: hdl/eevr_ctrl.sv
// Controller state machine of the edge event recorder: sequences each command
// through the datapath and owns both handshakes. Depends on eevr_pkg.
module eevr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  eevr_pkg::stat_type stat,
   output eevr_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_EV_SIZE, S_EV_CHECK, S_WR_DATA, S_WR_GLITCH,
      S_EV_COMMIT, S_RD_ISSUE, S_RD_TAKE, S_RD_EVAL, S_RD_DECIDE, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.res_code = eevr_pkg::ST_DONE;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            unique case (stat.mode)
               eevr_pkg::MODE_START: begin
                  cmd.start    = 1'b1;
                  cmd.set_res  = 1'b1;
                  cmd.res_code = eevr_pkg::ST_DONE;
               end
               eevr_pkg::MODE_EDGE: begin
                  if (stat.sig_enabled) begin
                     cmd.ev_prep = 1'b1;
                     state_in    = S_EV_SIZE;
                  end else begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = eevr_pkg::ST_IGNORED;
                  end
               end
               eevr_pkg::MODE_READ: begin
                  if (stat.ring_empty) begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = eevr_pkg::ST_NOTHING;
                  end else begin
                     cmd.rd_init = 1'b1;
                     state_in    = S_RD_ISSUE;
                  end
               end
               default: begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = eevr_pkg::ST_IGNORED;
               end
            endcase
         end
         S_EV_SIZE: begin
            cmd.ev_size = 1'b1;
            state_in    = S_EV_CHECK;
         end
         S_EV_CHECK: begin
            if (stat.ev_full) begin
               cmd.ev_fail  = 1'b1;
               cmd.set_res  = 1'b1;
               cmd.res_code = eevr_pkg::ST_FULL;
               state_in     = S_FINISH;
            end else begin
               state_in = S_WR_DATA;
            end
         end
         S_WR_DATA: begin
            cmd.wr_data = 1'b1;
            if (stat.wr_last) begin
               state_in = stat.glitch ? S_WR_GLITCH : S_EV_COMMIT;
            end
         end
         S_WR_GLITCH: begin
            cmd.wr_glitch = 1'b1;
            state_in      = S_EV_COMMIT;
         end
         S_EV_COMMIT: begin
            cmd.ev_commit = 1'b1;
            cmd.set_res   = 1'b1;
            cmd.res_code  = eevr_pkg::ST_DONE;
            state_in      = S_FINISH;
         end
         S_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RD_TAKE;
         end
         S_RD_TAKE: begin
            cmd.rd_take = 1'b1;
            state_in    = stat.rd_more ? S_RD_ISSUE : S_RD_EVAL;
         end
         S_RD_EVAL: begin
            cmd.rd_eval = 1'b1;
            state_in    = S_RD_DECIDE;
         end
         S_RD_DECIDE: begin
            cmd.set_res = 1'b1;
            if (stat.rd_ok) begin
               cmd.rd_commit = 1'b1;
               cmd.res_code  = eevr_pkg::ST_RECORD;
            end else begin
               cmd.res_code = eevr_pkg::ST_NOTHING;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DISPATCH) else $error("load did not lead to dispatch");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> slot_free) else $error("result register overwritten");
   a_take_after_issue: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_take |-> $past(cmd.rd_issue)) else $error("ring byte taken before read");
`endif

endmodule

// File: hdl/edge_event_varint_ring_recorder_top.sv
// Top level of the edge event recorder: joins the controller and the datapath.
// Depends on eevr_pkg, eevr_ctrl and eevr_dp.
//
// Records signal edges as delta-time varint records in a byte ring and reads
// them back one at a time. One command is worked on at a time; the next is
// accepted as soon as the controller is idle, even while the previous result
// waits to be taken. Start and ignored or empty commands go from dispatch
// straight to the result. An edge is sized and checked for room, then
// writes its 1 to 9 data bytes in turn through the single ring write port,
// plus a glitch byte if the level did not change, then commits; an edge that
// finds the ring full ends after the check. A read takes its record byte by
// byte, as each byte needs a memory read and a registered accumulate. There
// is no clearing pass after reset; only committed bytes are ever decoded.
module edge_event_varint_ring_recorder_top #(
   parameter int RING_DEPTH = 8192
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_mode,
   input  logic [eevr_pkg::SIG_W-1:0]         req_signal_index,
   input  logic                               req_pin_level,
   input  logic [eevr_pkg::TIME_W-1:0]        req_now_time,
   input  logic [eevr_pkg::MAX_SIGNALS-1:0]   req_start_levels,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic [eevr_pkg::SIG_W-1:0]         rsp_record_signal,
   output logic                               rsp_record_falling,
   output logic signed [eevr_pkg::AGE_W-1:0]  rsp_record_age,
   output logic                               rsp_overflow_seen,
   input  logic                               csr_write,
   input  logic                               csr_index,
   input  logic [eevr_pkg::CSR_W-1:0]         csr_data
);

   eevr_pkg::cmd_type  cmd;
   eevr_pkg::stat_type stat;

   eevr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   eevr_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_mode           (req_mode),
      .req_signal_index   (req_signal_index),
      .req_pin_level      (req_pin_level),
      .req_now_time       (req_now_time),
      .req_start_levels   (req_start_levels),
      .rsp_status         (rsp_status),
      .rsp_record_signal  (rsp_record_signal),
      .rsp_record_falling (rsp_record_falling),
      .rsp_record_age     (rsp_record_age),
      .rsp_overflow_seen  (rsp_overflow_seen)
   );

endmodule
